@@ hw/rtl/idle_timeout_command_spotter_assert.svh @@
// Assertion macros for the idle timeout command spotter.
// Each macro takes a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef IDLE_TIMEOUT_COMMAND_SPOTTER_ASSERT_SVH
`define IDLE_TIMEOUT_COMMAND_SPOTTER_ASSERT_SVH

`ifndef SYNTH
`define ITCS_ASSERT_SAME(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("same-cycle check failed");
`define ITCS_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ITCS_ASSERT_SAME(label, clk, rst_n, trig, cons)
`define ITCS_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif

`endif

@@ hw/rtl/itcs_pkg.sv @@
`default_nettype none

package itcs_pkg;

    localparam int KW_COUNT  = 12;
    localparam int WIN_DEPTH = 6;
    localparam int KW_MAX    = WIN_DEPTH + 1;

    // keyword indexes in the seen vector
    localparam int KW_GOOD        = 0;
    localparam int KW_OPEN        = 1;
    localparam int KW_FIRST_PANEL = 2;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [1:0] ALARM_NONE  = 2'd0;
    localparam logic [1:0] ALARM_CLEAR = 2'd1;
    localparam logic [1:0] ALARM_SET   = 2'd2;

    localparam logic [3:0] PANEL_NONE = 4'd0;

    typedef logic [7:0] byte_t;
    typedef logic [WIN_DEPTH-1:0][7:0] window_t;
    typedef logic [KW_MAX-1:0][7:0] history_t;
    typedef logic [KW_COUNT-1:0] kw_mask_t;

    // Keyword text, right aligned: byte 0 is the last character.
    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
        {24'h0, "good"},  {24'h0, "open"},
        {16'h0, "page0"}, {16'h0, "page1"}, {16'h0, "page2"},
        {16'h0, "page3"}, {16'h0, "page4"}, {16'h0, "page5"},
        {8'h0, "LED_ON"}, "LED_OFF", {8'h0, "FAN_ON"}, "FAN_OFF"
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd7, 3'd6, 3'd7
    };

    typedef struct packed {
        logic  action;
        byte_t rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] alarm_command;
        logic [3:0] panel_command;
        logic [6:0] frame_length;
    } out_item_t;

    // frame tracker status toward the handshake logic
    typedef struct packed {
        logic      closing;
        out_item_t result;
    } frame_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/itcs_chan_if.sv @@
`default_nettype none

interface itcs_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/itcs_matcher.sv @@
`default_nettype none

module itcs_matcher (
    input  wire itcs_pkg::window_t  window,
    input  wire itcs_pkg::byte_t    newest,
    output      itcs_pkg::kw_mask_t hits
);
    import itcs_pkg::*;

    history_t hist;

    assign hist = {window, newest};

    // every keyword checked in parallel, ending at the newest byte
    always_comb
    begin
        hits = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            hits[k] = 1'b1;
            for (int i = 0; i < KW_MAX; i++)
            begin
                if ((3'(i) < KW_LEN[k]) && (hist[i] != KW_TEXT[k][8*i +: 8]))
                begin
                    hits[k] = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/itcs_frame.sv @@
`default_nettype none

module itcs_frame #(
    parameter int FRAME_BYTES = 128
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        timeout_we,
    input  wire  [15:0]                timeout_wdata,
    input  wire                        fire,
    input  wire itcs_pkg::in_item_t    item,
    output      itcs_pkg::frame_stat_t stat
);
    import itcs_pkg::*;

    localparam int CW = $clog2(FRAME_BYTES);
    localparam logic [CW-1:0] COUNT_MAX = CW'(FRAME_BYTES - 1);

    window_t       window_reg, window_next;
    kw_mask_t      seen_reg, seen_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   idle_reg, idle_next;
    logic          ended_reg, ended_next;
    logic [15:0]   timeout_reg;
    kw_mask_t      hits;
    logic          closing;

    itcs_matcher u_matcher (
        .window (window_reg),
        .newest (item.rx_byte),
        .hits   (hits)
    );

    assign closing = (item.action == ACT_TICK) && (count_reg != '0)
                   && (idle_reg >= timeout_reg);

    always_comb
    begin
        stat.closing = closing;
        if (seen_reg[KW_GOOD])
        begin
            stat.result.alarm_command = ALARM_CLEAR;
        end
        else if (seen_reg[KW_OPEN])
        begin
            stat.result.alarm_command = ALARM_SET;
        end
        else
        begin
            stat.result.alarm_command = ALARM_NONE;
        end
        // lowest seen panel keyword wins
        stat.result.panel_command = PANEL_NONE;
        for (int k = KW_COUNT - 1; k >= KW_FIRST_PANEL; k--)
        begin
            if (seen_reg[k])
            begin
                stat.result.panel_command = 4'(k - 1);
            end
        end
        stat.result.frame_length = 7'(count_reg);
    end

    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        count_next  = count_reg;
        idle_next   = idle_reg;
        ended_next  = ended_reg;
        if (fire)
        begin
            case (item.action)
                ACT_BYTE:
                begin
                    idle_next = '0;
                    if (count_reg < COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                        if (!ended_reg)
                        begin
                            if (item.rx_byte == '0)
                            begin
                                ended_next = 1'b1;
                            end
                            else
                            begin
                                seen_next   = seen_reg | hits;
                                window_next = {window_reg[WIN_DEPTH-2:0], item.rx_byte};
                            end
                        end
                    end
                end
                ACT_TICK:
                begin
                    if (closing)
                    begin
                        window_next = '0;
                        seen_next   = '0;
                        count_next  = '0;
                        idle_next   = '0;
                        ended_next  = 1'b0;
                    end
                    else if (count_reg != '0)
                    begin
                        idle_next = idle_reg + 1'b1;
                    end
                end
                default:
                begin
                    idle_next = idle_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            seen_reg    <= '0;
            count_reg   <= '0;
            idle_reg    <= '0;
            ended_reg   <= 1'b0;
            timeout_reg <= 16'd100;
        end
        else
        begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
            count_reg  <= count_next;
            idle_reg   <= idle_next;
            ended_reg  <= ended_next;
            if (timeout_we)
            begin
                timeout_reg <= timeout_wdata;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/idle_timeout_command_spotter.sv @@
// Channel | Dir | Payload                                        | Transfer
// item    | in  | action (0 byte, 1 tick), rx_byte[7:0]          | valid & ready
// result  | out | alarm_command[1:0], panel_command[3:0],        | valid & ready
//         |     | frame_length[6:0]                              |
// timeout | in  | timeout_we, timeout_wdata[15:0]                | write on we
//
// One item per cycle sustained unless a closing tick is held in the stage.
// An item is registered in the input stage, then updates frame state; a
// closing tick lands in the result register in that same update.
// Throughput is set by the single frame-state update per cycle.
// Reset (rst_n, async) clears the frame and sets the timeout to 100.
// A closing tick waits in the input stage only while the result register is
// full and not being drained; bytes and other ticks never wait.
`default_nettype none
`include "idle_timeout_command_spotter_assert.svh"

module idle_timeout_command_spotter #(
    parameter int FRAME_BYTES = 128
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         timeout_we,
    input  wire  [15:0] timeout_wdata,
    itcs_chan_if.sink   item,
    itcs_chan_if.source result
);
    import itcs_pkg::*;

    // input stage
    logic        stage_valid_reg, stage_valid_next;
    in_item_t    stage_item_reg;
    // result register
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg;

    frame_stat_t stat;
    logic        can_proc;
    logic        proc_fire;
    logic        take_item;

    itcs_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_we    (timeout_we),
        .timeout_wdata (timeout_wdata),
        .fire          (proc_fire),
        .item          (stage_item_reg),
        .stat          (stat)
    );

    // only a closing tick needs room in the result register
    assign can_proc  = !stat.closing || !out_valid_reg || result.ready;
    assign proc_fire = stage_valid_reg && can_proc;
    assign take_item = item.valid && item.ready;

    assign item.ready     = !stage_valid_reg || proc_fire;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take_item)
        begin
            stage_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (proc_fire && stat.closing)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            stage_item_reg <= item.payload;
        end
        if (proc_fire && stat.closing)
        begin
            out_item_reg <= stat.result;
        end
    end

    // a processed closing tick always produces a result
    `ITCS_ASSERT_NEXT(a_close_loads, clk, rst_n, proc_fire && stat.closing, out_valid_reg)
    // a held stage item is never dropped
    `ITCS_ASSERT_NEXT(a_stage_kept, clk, rst_n, stage_valid_reg && !proc_fire, stage_valid_reg)
    // results come only from non-empty frames
    `ITCS_ASSERT_SAME(a_len_nonzero, clk, rst_n, out_valid_reg, out_item_reg.frame_length != 7'd0)

endmodule

`default_nettype wire
